/* hdl/ms_pkg.sv */
// ----------------------------------------------------------------------------
// ms_pkg: shared definitions for the merge sorter
// Capacity, derived widths and the command/status bundles that pass between
// the sort controller and the sort datapath.
// ----------------------------------------------------------------------------
package ms_pkg;

    // capacity of the element store and derived widths
    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int WID_W     = CNT_W + 1;

    // controller to datapath commands (at most one set per cycle)
    typedef struct packed {
        logic load;     // accept one input transaction
        logic setup;    // start a merge pass, or detect that sorting is done
        logic merge;    // move one element from source bank to destination
        logic emit;     // present one sorted element
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic sorted;   // run width already covers the whole set
        logic pass_end; // current merge step writes the last element of a pass
        logic emit_end; // current emit step presents the final element
    } t_dp_sts;

endpackage

/* hdl/ms_datapath.sv */
// ----------------------------------------------------------------------------
// ms_datapath: storage and merge engine of the merge sorter
// Two ping-pong element banks, run bookkeeping for a bottom-up merge and
// the read path that presents sorted elements. Banks read at two addresses
// per cycle with registered read data; one element is merged per merge command.
// ----------------------------------------------------------------------------
module ms_datapath import ms_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [DATA_W-1:0]       i_value,
    input  logic                    i_last_in,
    output t_dp_sts                 o_sts,
    output logic [DATA_W-1:0]       o_sorted_value,
    output logic                    o_last_out,
    output logic                    o_overflow
);

    // element banks
    logic [DATA_W-1:0] r_mem0 [MAX_ITEMS];
    logic [DATA_W-1:0] r_mem1 [MAX_ITEMS];

    // control state
    logic [CNT_W-1:0] r_n,    n_n;
    logic             r_drop, n_drop;

    // merge bookkeeping
    logic [CNT_W-1:0] r_i,   n_i;
    logic [CNT_W-1:0] r_j,   n_j;
    logic [CNT_W-1:0] r_k,   n_k;
    logic [CNT_W-1:0] r_mid, n_mid;
    logic [CNT_W-1:0] r_hi,  n_hi;
    logic [WID_W-1:0] r_width, n_width;
    logic             r_bank,  n_bank;

    // registered read data
    logic [DATA_W-1:0] r_rd0_a, r_rd0_b, r_rd1_a, r_rd1_b;
    logic              r_rd_sel;
    logic [DATA_W-1:0] rd_i, rd_j;

    // write ports
    logic              wr0_en, wr1_en;
    logic [IDX_W-1:0]  wr0_addr, wr1_addr;
    logic [DATA_W-1:0] wr0_data, wr1_data, merge_data;

    // helpers
    logic             avail_i, avail_j, take_j, run_end, pass_end, emit_end, sorted;
    logic [CNT_W:0]   i_inc, j_inc, k_inc;
    logic [CNT_W-1:0] base, run_mid, run_hi;
    logic [CNT_W+1:0] sum_mid, sum_hi, n_ext;

    assign rd_i = r_rd_sel ? r_rd1_a : r_rd0_a;
    assign rd_j = r_rd_sel ? r_rd1_b : r_rd0_b;

    // run bounds and merge decision
    always_comb begin
        i_inc   = {1'b0, r_i} + 1'b1;
        j_inc   = {1'b0, r_j} + 1'b1;
        k_inc   = {1'b0, r_k} + 1'b1;
        avail_i = (r_i < r_mid);
        avail_j = (r_j < r_hi);
        take_j  = avail_j && (!avail_i || ($signed(rd_j) < $signed(rd_i)));
        merge_data = take_j ? rd_j : rd_i;
        run_end  = (k_inc == {1'b0, r_hi});
        pass_end = run_end && (r_hi == r_n);
        emit_end = (i_inc == {1'b0, r_n});
        sorted   = (r_width >= {1'b0, r_n});
        base     = i_cmd.setup ? '0 : r_hi;
        sum_mid  = {2'b00, base} + {1'b0, r_width};
        sum_hi   = {2'b00, base} + {r_width, 1'b0};
        n_ext    = {2'b00, r_n};
        run_mid  = (sum_mid > n_ext) ? r_n : sum_mid[CNT_W-1:0];
        run_hi   = (sum_hi  > n_ext) ? r_n : sum_hi[CNT_W-1:0];
    end

    // next-state logic
    always_comb begin
        n_n      = r_n;
        n_drop   = r_drop;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        n_mid    = r_mid;
        n_hi     = r_hi;
        n_width  = r_width;
        n_bank   = r_bank;
        wr0_en   = 1'b0;
        wr1_en   = 1'b0;
        wr0_addr = r_k[IDX_W-1:0];
        wr1_addr = r_k[IDX_W-1:0];
        wr0_data = merge_data;
        wr1_data = merge_data;
        if (i_cmd.load) begin
            if (r_n < CNT_W'(MAX_ITEMS)) begin
                wr0_en   = 1'b1;
                wr0_addr = r_n[IDX_W-1:0];
                wr0_data = i_value;
                n_n      = r_n + 1'b1;
            end else begin
                n_drop = 1'b1;
            end
            if (i_last_in) begin
                n_width = WID_W'(1);
                n_bank  = 1'b0;
            end
        end else if (i_cmd.setup) begin
            n_i = '0;
            n_k = '0;
            if (!sorted) begin
                n_mid = run_mid;
                n_hi  = run_hi;
                n_j   = run_mid;
            end
        end else if (i_cmd.merge) begin
            // source is r_bank, destination the other bank
            wr0_en = r_bank;
            wr1_en = !r_bank;
            n_k    = k_inc[CNT_W-1:0];
            if (take_j) begin
                n_j = j_inc[CNT_W-1:0];
            end else begin
                n_i = i_inc[CNT_W-1:0];
            end
            if (pass_end) begin
                n_width = {r_width[WID_W-2:0], 1'b0};
                n_bank  = !r_bank;
            end else if (run_end) begin
                n_i   = r_hi;
                n_mid = run_mid;
                n_hi  = run_hi;
                n_j   = run_mid;
            end
        end else if (i_cmd.emit) begin
            n_i = i_inc[CNT_W-1:0];
            if (emit_end) begin
                n_n    = '0;
                n_drop = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n    <= '0;
            r_drop <= 1'b0;
        end else begin
            r_n    <= n_n;
            r_drop <= n_drop;
        end
    end

    // bookkeeping registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_width <= n_width;
        r_bank  <= n_bank;
    end

    // bank 0: write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr0_en) begin
            r_mem0[wr0_addr] <= wr0_data;
        end
        r_rd0_a <= r_mem0[n_i[IDX_W-1:0]];
        r_rd0_b <= r_mem0[n_j[IDX_W-1:0]];
    end

    // bank 1: write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr1_en) begin
            r_mem1[wr1_addr] <= wr1_data;
        end
        r_rd1_a <= r_mem1[n_i[IDX_W-1:0]];
        r_rd1_b <= r_mem1[n_j[IDX_W-1:0]];
    end

    // read data follows the bank that the addresses were meant for
    always_ff @(posedge i_clk) begin
        r_rd_sel <= n_bank;
    end

    assign o_sts.sorted   = sorted;
    assign o_sts.pass_end = pass_end;
    assign o_sts.emit_end = emit_end;

    assign o_sorted_value = rd_i;
    assign o_last_out     = emit_end;
    assign o_overflow     = r_drop;

    // element count never exceeds the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(MAX_ITEMS))
        else $error("element count above capacity");

    // a merge step always has at least one run element left
    a_merge_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (avail_i || avail_j))
        else $error("merge step with both runs exhausted");

    // run cursors stay within their runs while merging
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge |-> (r_i <= r_mid) && (r_j <= r_hi) && (r_k < r_hi))
        else $error("merge cursor outside its run");

endmodule

/* hdl/ms_ctrl.sv */
// ----------------------------------------------------------------------------
// ms_ctrl: sequencing of the merge sorter
// Load phase, merge passes and emission, issued as commands to the datapath.
// ----------------------------------------------------------------------------
module ms_ctrl import ms_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_last_in,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy,
    output logic    o_strobe
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PASS  = 4'b0010,
        ST_MERGE = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) begin
                        n_state = ST_PASS;
                    end
                end
            end
            ST_PASS: begin
                o_cmd.setup = 1'b1;
                n_state = i_sts.sorted ? ST_EMIT : ST_MERGE;
            end
            ST_MERGE: begin
                o_cmd.merge = 1'b1;
                if (i_sts.pass_end) begin
                    n_state = ST_PASS;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.emit_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_strobe = (r_state == ST_EMIT);

    // a last transaction always starts sorting in the next cycle
    a_last_starts_sort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_in) |=> (r_state == ST_PASS))
        else $error("last transaction did not start a sort");

    // emission is entered only from a pass check
    a_emit_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> ($past(r_state) == ST_PASS))
        else $error("emission entered outside a pass check");

    // results only come out while the block is busy
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_busy)
        else $error("result strobe while idle");

endmodule

/* hdl/merge_sorter.sv */
// ----------------------------------------------------------------------------
// merge_sorter: collects signed 32-bit values and emits them sorted
// Sequence: a non-last transaction is loaded while the block stays idle;
//   after the last one the bottom-up merge runs ceil(log2 n) passes, each a
//   setup step and then one merged element per cycle (bounded by the bank
//   read/write ports), then a check step, then n results on consecutive
//   cycles, o_busy high throughout. No new element is taken until then.
// Reset: synchronous active-low clears the count, overflow flag and
//   controller; results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module merge_sorter import ms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_last_in,
    output logic              o_strobe,
    output logic [DATA_W-1:0] o_sorted_value,
    output logic              o_last_out,
    output logic              o_overflow
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    ms_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_last_in (i_last_in),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_busy    (o_busy),
        .o_strobe  (o_strobe)
    );

    // storage and merge engine
    ms_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_sts          (sts),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

endmodule

/* dv/merge_sorter_check.sv */
// ----------------------------------------------------------------------------
// merge_sorter_check: scoreboard for the merge sorter
// Watches the command and result channels at every rising edge. It keeps its
// own copy of the held set, sorts it when the closing element is accepted,
// and compares each strobed result with the oldest expected one.
// ----------------------------------------------------------------------------
module merge_sorter_check import ms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [DATA_W-1:0] i_value,
    input  logic              i_last_in,
    input  logic              i_strobe,
    input  logic [DATA_W-1:0] i_sorted_value,
    input  logic              i_last_out,
    input  logic              i_overflow,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last_out;
        logic              overflow;
    } t_sorted_result;

    // predictor state
    logic signed [DATA_W-1:0] held_values [MAX_ITEMS];
    int                       held_count;
    logic                     dropped;
    t_sorted_result           sorted_queue [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        held_count   = 0;
        dropped      = 1'b0;
    end

    // ascending insertion sort of the held set
    task automatic sort_held_values(input int n);
        logic signed [DATA_W-1:0] key;
        int                       j;
        for (int i = 1; i < n; i++) begin
            key = held_values[i];
            j   = i - 1;
            while (j >= 0 && held_values[j] > key) begin
                held_values[j+1] = held_values[j];
                j--;
            end
            held_values[j+1] = key;
        end
    endtask

    // one accepted element: store or drop it, and on the closing one queue the sorted set
    task automatic absorb_element(input logic [DATA_W-1:0] v, input logic closing);
        t_sorted_result r;
        if (held_count < MAX_ITEMS) begin
            held_values[held_count] = v;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (closing) begin
            sort_held_values(held_count);
            for (int k = 0; k < held_count; k++) begin
                r.value    = held_values[k];
                r.last_out = (k == held_count - 1);
                r.overflow = dropped;
                sorted_queue.push_back(r);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endtask

    // compare one strobed result with the oldest expectation
    task automatic check_result();
        t_sorted_result want;
        if (sorted_queue.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_MAX)
                $display("unexpected result: sorted_value %0d last_out %0b overflow %0b",
                         $signed(i_sorted_value), i_last_out, i_overflow);
        end else begin
            want = sorted_queue.pop_front();
            o_checked++;
            if (want.value !== i_sorted_value || want.last_out !== i_last_out ||
                want.overflow !== i_overflow) begin
                o_fail_count++;
                // fields in order sorted_value / last_out / overflow
                if (o_fail_count <= REPORT_MAX)
                    $display("mismatch exp %0d/%0b/%0b got %0d/%0b/%0b",
                             $signed(want.value), want.last_out, want.overflow,
                             $signed(i_sorted_value), i_last_out, i_overflow);
            end
        end
    endtask

    // results first, then the accepted command transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            dropped    = 1'b0;
            sorted_queue.delete();
        end else begin
            if (i_strobe === 1'b1)
                check_result();
            if (i_start && !i_busy)
                absorb_element(i_value, i_last_in);
        end
        o_pending = sorted_queue.size();
    end

endmodule

/* dv/merge_sorter_test.sv */
// ----------------------------------------------------------------------------
// merge_sorter_test: top level of the merge sorter testbench
// Drives sets of signed values through the start/busy handshake with random
// gaps: directed extremes first, then random sets of mostly small size, one
// full set and one overflowing set. The checker beside the block scores the
// sorted output; this module gives the verdict.
// ----------------------------------------------------------------------------
module merge_sorter_test;
    import ms_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 40;

    // value styles for random sets
    localparam int VAL_FULL    = 0;
    localparam int VAL_NARROW  = 1;
    localparam int VAL_EXTREME = 2;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [DATA_W-1:0] i_value;
    logic              i_last_in;
    logic              o_strobe;
    logic [DATA_W-1:0] o_sorted_value;
    logic              o_last_out;
    logic              o_overflow;

    int fail_count;
    int pending;
    int checked;
    int idle_pct;
    int items_sent;
    int sets_sent;
    int overflow_sets;
    int largest_set;

    merge_sorter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_last_out     (o_last_out),
        .o_overflow     (o_overflow)
    );

    merge_sorter_check i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_value        (i_value),
        .i_last_in      (i_last_in),
        .i_strobe       (o_strobe),
        .i_sorted_value (o_sorted_value),
        .i_last_out     (o_last_out),
        .i_overflow     (o_overflow),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // one command transaction, with an optional random gap ahead of it
    task automatic send_element(input logic [DATA_W-1:0] v, input logic closing);
        int gap;
        gap = 0;
        // each cycle idles with the given chance
        while ($urandom_range(99) < idle_pct)
            gap++;
        repeat (gap) begin
            @(negedge i_clk);
            i_start   <= 1'b0;
            i_value   <= $urandom;
            i_last_in <= 1'($urandom_range(1));
        end
        @(negedge i_clk);
        i_start   <= 1'b1;
        i_value   <= v;
        i_last_in <= closing;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
    endtask

    // hold off until every queued result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value(input int style);
        int narrow;
        case (style)
            VAL_NARROW: begin
                narrow = $urandom_range(6);
                return narrow - 3;
            end
            VAL_EXTREME: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // whole set of n elements, closing flag on the final one
    task automatic send_set(input int n, input int style);
        for (int i = 0; i < n; i++)
            send_element(pick_value(style), i == n - 1);
        sets_sent++;
        if (n > MAX_ITEMS)
            overflow_sets++;
        if (n > largest_set)
            largest_set = n;
    endtask

    initial begin
        int set_idx;
        int size;
        int start_items;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_value       = '0;
        i_last_in     = 1'b0;
        idle_pct      = 29;
        items_sent    = 0;
        sets_sent     = 0;
        overflow_sets = 0;
        largest_set   = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: value extremes in one set
        send_element(32'h7fff_ffff, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hffff_ffff, 1'b0);
        send_element(32'h0000_0001, 1'b1);
        // single-element set
        send_element(32'h8000_0000, 1'b1);
        // equal values
        send_element(32'd5, 1'b0);
        send_element(32'd5, 1'b0);
        send_element(-32'sd5, 1'b0);
        send_element(32'd5, 1'b1);
        // descending input, then a pause until all results are out
        for (int i = 0; i < 6; i++)
            send_element(6 - 2 * i, i == 5);
        wait_drained();
        // already ascending pair
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7fff_ffff, 1'b1);
        sets_sent   = 5;
        largest_set = 6;

        // random sets: mostly small, one full, one overflowing
        start_items = items_sent;
        set_idx     = 0;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            if (items_sent - start_items >= 150 && items_sent - start_items < 260)
                idle_pct = 0;
            else
                idle_pct = 29;
            if (set_idx == 6)
                size = MAX_ITEMS;
            else if (set_idx == 14)
                size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
            else if ($urandom_range(9) == 0)
                size = 1;
            else
                size = $urandom_range(2, 12);
            send_set(size, $urandom_range(VAL_EXTREME));
            if ($urandom_range(7) == 0)
                wait_drained();
            set_idx++;
        end

        // end of stimulus: drop start, drain, then let the block settle
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d elements in %0d sets (largest %0d, %0d overflowing)",
                 items_sent, sets_sent, largest_set, overflow_sets);
        $display("checked %0d sorted results, %0d failures", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/ms_pkg.sv
hdl/ms_datapath.sv
hdl/ms_ctrl.sv
hdl/merge_sorter.sv
dv/merge_sorter_check.sv
dv/merge_sorter_test.sv
